### hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types, microcode encoding and the control program of the
// trial division prime test unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // field widths of the control word
  localparam int STEP_W = 4;
  localparam int ACT_W  = 4;
  localparam int COND_W = 3;

  // default operand width
  localparam int VALUE_WIDTH_DEF = 32;

  // wheel constants: first divisor, period, gap to the second divisor, and 3
  localparam int WHEEL_START = 5;
  localparam int WHEEL_STEP  = 6;
  localparam int WHEEL_GAP   = 2;
  localparam int THREE       = 3;

  // datapath actions
  localparam logic [ACT_W-1:0] ACT_NONE  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_DIV3  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DIVD  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_DIVD2 = 4'd4;
  localparam logic [ACT_W-1:0] ACT_WAIT  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SETD  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_ADDD  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_EMIT1 = 4'd8;
  localparam logic [ACT_W-1:0] ACT_EMIT0 = 4'd9;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] C_SMALL  = 3'd2;
  localparam logic [COND_W-1:0] C_TWO3   = 3'd3;
  localparam logic [COND_W-1:0] C_EVEN   = 3'd4;
  localparam logic [COND_W-1:0] C_REM0   = 3'd5;
  localparam logic [COND_W-1:0] C_DGTQ   = 3'd6;

  // program step labels
  localparam logic [STEP_W-1:0] S_LOAD   = 4'd0;
  localparam logic [STEP_W-1:0] S_SMALL  = 4'd1;
  localparam logic [STEP_W-1:0] S_TWO3   = 4'd2;
  localparam logic [STEP_W-1:0] S_EVEN   = 4'd3;
  localparam logic [STEP_W-1:0] S_DIV3   = 4'd4;
  localparam logic [STEP_W-1:0] S_WAIT3  = 4'd5;
  localparam logic [STEP_W-1:0] S_SETD   = 4'd6;
  localparam logic [STEP_W-1:0] S_DIVD   = 4'd7;
  localparam logic [STEP_W-1:0] S_WAITD  = 4'd8;
  localparam logic [STEP_W-1:0] S_REMD   = 4'd9;
  localparam logic [STEP_W-1:0] S_DIVD2  = 4'd10;
  localparam logic [STEP_W-1:0] S_WAITD2 = 4'd11;
  localparam logic [STEP_W-1:0] S_ADDD   = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT1  = 4'd13;
  localparam logic [STEP_W-1:0] S_EMIT0  = 4'd14;

  // one control word
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_block;
    logic below2;
    logic two3;
    logic even;
    logic rem0;
    logic d_gt_q;
  } status_t;

  // control program rom
  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      S_LOAD:   w = '{ACT_LOAD,  C_NEVER,  S_LOAD};
      S_SMALL:  w = '{ACT_NONE,  C_SMALL,  S_EMIT0};
      S_TWO3:   w = '{ACT_NONE,  C_TWO3,   S_EMIT1};
      S_EVEN:   w = '{ACT_NONE,  C_EVEN,   S_EMIT0};
      S_DIV3:   w = '{ACT_DIV3,  C_NEVER,  S_LOAD};
      S_WAIT3:  w = '{ACT_WAIT,  C_REM0,   S_EMIT0};
      S_SETD:   w = '{ACT_SETD,  C_NEVER,  S_LOAD};
      S_DIVD:   w = '{ACT_DIVD,  C_NEVER,  S_LOAD};
      S_WAITD:  w = '{ACT_WAIT,  C_DGTQ,   S_EMIT1};
      S_REMD:   w = '{ACT_NONE,  C_REM0,   S_EMIT0};
      S_DIVD2:  w = '{ACT_DIVD2, C_NEVER,  S_LOAD};
      S_WAITD2: w = '{ACT_WAIT,  C_REM0,   S_EMIT0};
      S_ADDD:   w = '{ACT_ADDD,  C_ALWAYS, S_DIVD};
      S_EMIT1:  w = '{ACT_EMIT1, C_ALWAYS, S_LOAD};
      S_EMIT0:  w = '{ACT_EMIT0, C_ALWAYS, S_LOAD};
      default:  w = '{ACT_EMIT0, C_ALWAYS, S_LOAD};
    endcase
    return w;
  endfunction

endpackage

### hdl/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring divider, one quotient bit per cycle.
// Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module tdpt_divider #(
  parameter int W = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W:0]    trial;

  // operand load on start, else one shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[W-1]} - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      quo_nxt  = num_i;
      rem_nxt  = '0;
      den_nxt  = den_i;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy_o = busy_r;
  assign quo_o  = quo_r;
  assign rem_o  = rem_r;

endmodule

### hdl/tdpt_sequencer.sv
// ----------------------------------------------------------------------------
// tdpt_sequencer
// Step counter over the control rom with conditional jumps; holds a step
// while it waits for an input, the divider or a free output register.
// ----------------------------------------------------------------------------
module tdpt_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  tdpt_pkg::status_t status_i,
  output tdpt_pkg::ctrl_t   ctrl_o,
  output logic              adv_o
);

  logic [tdpt_pkg::STEP_W-1:0] step_r, step_nxt;
  tdpt_pkg::ctrl_t             word;
  logic                        hold;
  logic                        take;

  assign word = tdpt_pkg::ucode_word(step_r);

  // wait conditions
  always_comb begin
    case (word.act)
      tdpt_pkg::ACT_LOAD:  hold = !status_i.in_valid;
      tdpt_pkg::ACT_WAIT:  hold = status_i.div_busy;
      tdpt_pkg::ACT_EMIT0: hold = status_i.out_block;
      tdpt_pkg::ACT_EMIT1: hold = status_i.out_block;
      default:             hold = 1'b0;
    endcase
  end

  // jump condition select
  always_comb begin
    case (word.cond)
      tdpt_pkg::C_NEVER:  take = 1'b0;
      tdpt_pkg::C_ALWAYS: take = 1'b1;
      tdpt_pkg::C_SMALL:  take = status_i.below2;
      tdpt_pkg::C_TWO3:   take = status_i.two3;
      tdpt_pkg::C_EVEN:   take = status_i.even;
      tdpt_pkg::C_REM0:   take = status_i.rem0;
      tdpt_pkg::C_DGTQ:   take = status_i.d_gt_q;
      default:            take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + tdpt_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tdpt_pkg::S_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl_o = word;
  assign adv_o  = !hold;

endmodule

### hdl/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test by trial division over the 6k-1 / 6k+1 wheel.
// ----------------------------------------------------------------------------
// Usage:
//   in_value (signed) enters on the input channel; one transaction on the
//   output channel returns out_is_prime for it, in order.
//   Negative values, 0 and 1 give 0; 2 and 3 give 1; multiples of 2 or 3
//   give 0; otherwise divisors d and d+2 for d = 5, 11, 17, ... are tried
//   while d <= value / d.
// Item flow:
//   one item at a time; in_stall is low only in the load step.
//   Each remainder takes one pass of the shared restoring divider; a prime
//   runs about sqrt(value) / 6 wheel rounds; composites leave earlier.
// Reset:
//   synchronous active-low rst_n returns the sequencer to the load step and
//   empties the output register. No state is kept between items.
// Stall:
//   the result waits in the output register while out_stall is high; the
//   sequencer holds in its emit step until the register can take a result.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_prime
);

  localparam int W = VALUE_WIDTH;

  tdpt_pkg::ctrl_t   ctrl;
  tdpt_pkg::status_t status;
  logic              adv;

  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         is_prime_r, is_prime_nxt;

  logic         div_start;
  logic [W-1:0] div_den;
  logic         div_busy;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  // control program
  tdpt_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .ctrl_o   (ctrl),
    .adv_o    (adv)
  );

  // shared divider
  tdpt_divider #(
    .W (W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (n_r),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // divider start and divisor select
  always_comb begin
    div_start = 1'b0;
    div_den   = d_r;
    case (ctrl.act)
      tdpt_pkg::ACT_DIV3: begin
        div_start = 1'b1;
        div_den   = W'(tdpt_pkg::THREE);
      end
      tdpt_pkg::ACT_DIVD: begin
        div_start = 1'b1;
        div_den   = d_r;
      end
      tdpt_pkg::ACT_DIVD2: begin
        div_start = 1'b1;
        div_den   = d_r + W'(tdpt_pkg::WHEEL_GAP);
      end
      default: begin
        div_start = 1'b0;
        div_den   = d_r;
      end
    endcase
  end

  // status flags for the wait and jump conditions
  always_comb begin
    status.in_valid  = in_valid;
    status.div_busy  = div_busy;
    status.out_block = out_valid_r && out_stall;
    status.below2    = n_r[W-1] || (n_r <= W'(1));
    status.two3      = (n_r == W'(tdpt_pkg::WHEEL_GAP)) || (n_r == W'(tdpt_pkg::THREE));
    status.even      = !n_r[0];
    status.rem0      = (div_rem == '0);
    status.d_gt_q    = (d_r > div_quo);
  end

  // datapath register updates
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    is_prime_nxt  = is_prime_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      case (ctrl.act)
        tdpt_pkg::ACT_LOAD:  n_nxt = in_value;
        tdpt_pkg::ACT_SETD:  d_nxt = W'(tdpt_pkg::WHEEL_START);
        tdpt_pkg::ACT_ADDD:  d_nxt = d_r + W'(tdpt_pkg::WHEEL_STEP);
        tdpt_pkg::ACT_EMIT1: begin
          is_prime_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
        tdpt_pkg::ACT_EMIT0: begin
          is_prime_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
        default: begin
          n_nxt = n_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    is_prime_r <= is_prime_nxt;
  end

  // ports
  assign in_stall     = (ctrl.act != tdpt_pkg::ACT_LOAD);
  assign out_valid    = out_valid_r;
  assign out_is_prime = is_prime_r;

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_den != '0))
    else $error("divider started with zero divisor");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken before the first finished");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(ctrl.act) == tdpt_pkg::ACT_EMIT0 ||
                            $past(ctrl.act) == tdpt_pkg::ACT_EMIT1))
    else $error("result raised outside an emit step");

endmodule
